// File: design/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Used by ple_ctrl, ple_cell and positional_list_engine_core; depends on nothing.
`default_nettype none

package ple_pkg;

	// Capacity of the list and the widths derived from it.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the transactions.
	localparam int ACT_W    = 2;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int ST_W     = 2;
	localparam int CNTOUT_W = 7;

	// Width that holds both a position and a count plus one without overflow.
	localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_EDIT   = 2'd2,
		ACT_READ   = 2'd3
	} ple_action_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} ple_status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                    shift_up;
		logic                    shift_down;
		logic                    wr_en;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
	} ple_cmd_t;

	// Outcome of one transaction as seen by the result side.
	typedef struct packed {
		ple_status_t      status;
		logic             rd_en;
		logic [CNT_W-1:0] count_nxt;
	} ple_res_t;

endpackage

`default_nettype wire

// File: design/positional_list_engine_core.sv
// Top level of the positional list engine: cell chain, count register and result register.
// Depends on ple_pkg, ple_ctrl and ple_cell.
//
// The block keeps an ordered list of up to ple_pkg::CAPACITY signed 32-bit entries in a
// chain of cells, one entry per cell. Each input transaction is an insert, remove, edit
// or read at a 1-based position; an insert or remove moves every later entry by one cell
// in the same clock, and a new transaction is taken in
// every cycle in which the result register is empty or being drained. Each transaction
// yields one result with the value read (zero unless a successful read), a status (done,
// position out of range, or list full on insert) and the entry count after the action.
// A bad position or a full list leaves the contents unchanged.
`default_nettype none

module positional_list_engine_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [ple_pkg::ACT_W-1:0]           action,
	input  wire logic [ple_pkg::POS_W-1:0]           position,
	input  wire logic signed [ple_pkg::VAL_W-1:0]    new_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [ple_pkg::VAL_W-1:0]         read_value,
	output logic [ple_pkg::ST_W-1:0]                 status,
	output logic [ple_pkg::CNTOUT_W-1:0]             entry_count
);

	logic                              accept;
	logic                              out_valid_q;
	logic [ple_pkg::CNT_W-1:0]         count_q;
	logic signed [ple_pkg::VAL_W-1:0]  read_value_q;
	logic [ple_pkg::ST_W-1:0]          status_q;
	logic [ple_pkg::CNTOUT_W-1:0]      entry_count_q;
	ple_pkg::ple_cmd_t                 cmd;
	ple_pkg::ple_res_t                 res;
	logic signed [ple_pkg::VAL_W-1:0]  cell_val [ple_pkg::CAPACITY];

	// A transaction is taken when the result register is free or drains this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	ple_ctrl u_ctrl (
		.go        (accept),
		.action    (action),
		.position  (position),
		.new_value (new_value),
		.count     (count_q),
		.cmd       (cmd),
		.res       (res)
	);

	// Chain of cells; the ends see zero from the missing neighbor.
	for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
		logic signed [ple_pkg::VAL_W-1:0] left_val;
		logic signed [ple_pkg::VAL_W-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == ple_pkg::CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end
		ple_cell u_cell (
			.clk       (clk),
			.my_idx    (ple_pkg::IDX_W'(i)),
			.cmd       (cmd),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i])
		);
	end

	// Control state: result valid flag and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				count_q     <= res.count_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded with each accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= res.rd_en ? cell_val[cmd.idx] : '0;
			status_q      <= ple_pkg::ST_W'(res.status);
			entry_count_q <= ple_pkg::CNTOUT_W'(res.count_nxt);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

// File: design/ple_ctrl.sv
// Action decode and range checks for the positional list engine.
// Depends on ple_pkg for the command and result types.
`default_nettype none

module ple_ctrl (
	input  wire logic                            go,
	input  wire logic [ple_pkg::ACT_W-1:0]       action,
	input  wire logic [ple_pkg::POS_W-1:0]       position,
	input  wire logic signed [ple_pkg::VAL_W-1:0] new_value,
	input  wire logic [ple_pkg::CNT_W-1:0]       count,
	output ple_pkg::ple_cmd_t                    cmd,
	output ple_pkg::ple_res_t                    res
);

	logic [ple_pkg::CMP_W-1:0] pos_w;
	logic [ple_pkg::CMP_W-1:0] cnt_w;
	logic                      pos_nonzero;
	logic                      ins_pos_ok;
	logic                      acc_pos_ok;
	logic                      full;
	ple_pkg::ple_action_t      act;

	// Widen both operands so that count plus one cannot wrap.
	assign pos_w       = ple_pkg::CMP_W'(position);
	assign cnt_w       = ple_pkg::CMP_W'(count);
	assign pos_nonzero = (position != '0);
	assign ins_pos_ok  = pos_nonzero && (pos_w <= cnt_w + ple_pkg::CMP_W'(1));
	assign acc_pos_ok  = pos_nonzero && (pos_w <= cnt_w);
	assign full        = (cnt_w >= ple_pkg::CMP_W'(ple_pkg::CAPACITY));
	assign act         = ple_pkg::ple_action_t'(action);

	// Build the cell command and the status of the transaction.
	always_comb begin
		cmd.shift_up   = 1'b0;
		cmd.shift_down = 1'b0;
		cmd.wr_en      = 1'b0;
		cmd.idx        = ple_pkg::IDX_W'(position - ple_pkg::POS_W'(1));
		cmd.value      = new_value;
		res.status     = ple_pkg::ST_DONE;
		res.rd_en      = 1'b0;
		res.count_nxt  = count;
		case (act)
			ple_pkg::ACT_INSERT: begin
				if (!ins_pos_ok) begin
					res.status = ple_pkg::ST_RANGE;
				end else if (full) begin
					res.status = ple_pkg::ST_FULL;
				end else begin
					cmd.shift_up  = go;
					cmd.wr_en     = go;
					res.count_nxt = count + ple_pkg::CNT_W'(1);
				end
			end
			ple_pkg::ACT_REMOVE: begin
				if (!acc_pos_ok) begin
					res.status = ple_pkg::ST_RANGE;
				end else begin
					cmd.shift_down = go;
					res.count_nxt  = count - ple_pkg::CNT_W'(1);
				end
			end
			ple_pkg::ACT_EDIT: begin
				if (!acc_pos_ok) begin
					res.status = ple_pkg::ST_RANGE;
				end else begin
					cmd.wr_en = go;
				end
			end
			ple_pkg::ACT_READ: begin
				if (!acc_pos_ok) begin
					res.status = ple_pkg::ST_RANGE;
				end else begin
					res.rd_en = 1'b1;
				end
			end
			default: begin
				res.status = ple_pkg::ST_RANGE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/ple_cell.sv
// One cell of the list chain: holds a single entry and trades it with its neighbors.
// Depends on ple_pkg for the command type.
`default_nettype none

module ple_cell (
	input  wire logic                             clk,
	input  wire logic [ple_pkg::IDX_W-1:0]        my_idx,
	input  wire ple_pkg::ple_cmd_t                cmd,
	input  wire logic signed [ple_pkg::VAL_W-1:0] left_val,
	input  wire logic signed [ple_pkg::VAL_W-1:0] right_val,
	output logic signed [ple_pkg::VAL_W-1:0]      val
);

	logic signed [ple_pkg::VAL_W-1:0] val_q;
	logic signed [ple_pkg::VAL_W-1:0] val_nxt;

	// Pick the next entry: new value at the target, neighbor above or below it.
	always_comb begin
		val_nxt = val_q;
		if (cmd.wr_en && (my_idx == cmd.idx)) begin
			val_nxt = cmd.value;
		end else if (cmd.shift_up && (my_idx > cmd.idx)) begin
			val_nxt = left_val;
		end else if (cmd.shift_down && (my_idx >= cmd.idx)) begin
			val_nxt = right_val;
		end
	end

	// Entry storage; no reset, entries are written before they are read.
	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	assign val = val_q;

endmodule

`default_nettype wire
